/* rtl/distance_vector_table_update_top_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the routing table block
// Clocked on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_TABLE_UPDATE_TOP_ASSERT_SVH
`define DISTANCE_VECTOR_TABLE_UPDATE_TOP_ASSERT_SVH

// same-cycle implication
`define DVTU_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("dvtu assertion failed");

// next-cycle implication
`define DVTU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("dvtu assertion failed");

`endif

/* rtl/dvtu_pkg.sv */
// ----------------------------------------------------------------------------
// dvtu_pkg
// Types and constants shared by the routing table block and its checker.
// ----------------------------------------------------------------------------
package dvtu_pkg;

    // node fields are 4 bits wide, so no more rows than this are reachable
    localparam int NODE_LIMIT = 16;

    localparam logic [4:0] DIST_MAX  = 5'd31;
    localparam logic [4:0] COUNT_MAX = 5'd31;

    typedef enum logic [1:0] {
        OP_LINK = 2'd0,
        OP_ADV  = 2'd1,
        OP_READ = 2'd2,
        OP_NOP  = 2'd3
    } t_op;

    typedef struct packed {
        logic [1:0] operation;
        logic [3:0] first_node;
        logic [3:0] second_node;
    } t_in;

    typedef struct packed {
        logic       known;
        logic [4:0] distance;
        logic [3:0] next_hop;
        logic [4:0] updated_count;
    } t_out;

    // one table entry as held in memory
    typedef struct packed {
        logic       known;
        logic [4:0] distance;
        logic [3:0] next_hop;
    } t_entry;

endpackage

/* rtl/dvtu_ram.sv */
// ----------------------------------------------------------------------------
// dvtu_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module dvtu_ram #(
    parameter int WIDTH = 10,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

/* rtl/distance_vector_table_update_top.sv */
// ----------------------------------------------------------------------------
// distance_vector_table_update_top
// Per-node distance-vector routing tables held in one RAM, row = owner,
// column = destination; add-link, advertise and read operations.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+-------------------
//   in      | input     | i_in_valid / o_in_ready    | i_in_item  (t_in)
//   out     | output    | o_out_valid / i_out_ready  | o_out_item (t_out)
//
// One item at a time, o_in_ready high only when idle. Advertise walks the
// min(NODES,16) columns, one column a cycle on both read ports, write back
// following the registered read; add-link makes two writes on one port; read does
// one lookup; other items and self-advertise skip to the result. Each entry
// has a valid flop: unwritten, it reads as its reset value, no clearing pass.
// A stalled result sits in the output register; the next item runs and waits.
// ----------------------------------------------------------------------------
module distance_vector_table_update_top #(
    parameter int NODES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  dvtu_pkg::t_in i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output dvtu_pkg::t_out o_out_item
);

    import dvtu_pkg::*;

    localparam int NU    = (NODES < NODE_LIMIT) ? NODES : NODE_LIMIT;
    localparam int CW    = $clog2(NU);
    localparam int DEPTH = NU * (2 ** CW);
    localparam int AW    = 2 * CW;
    localparam int EW    = $bits(t_entry);

    localparam logic [8:0]    NODES_V  = 9'(NODES);
    localparam logic [CW-1:0] LAST_COL = CW'(NU - 1);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LINK1 = 8'b0000_0010,
        S_LINK2 = 8'b0000_0100,
        S_ADV   = 8'b0000_1000,
        S_ADVT  = 8'b0001_0000,
        S_RDI   = 8'b0010_0000,
        S_RDW   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } t_state;

    t_state        r_state, n_state;
    logic [3:0]    r_a, n_a;
    logic [3:0]    r_b, n_b;
    logic [CW-1:0] r_col, n_col;
    logic          r_pend, n_pend;
    logic [4:0]    r_cnt, n_cnt;
    t_out          r_res, n_res;
    t_out          r_out, n_out;
    logic          r_out_vld, n_out_vld;

    logic          r_ent_vld [DEPTH];
    logic          r_va, r_vb;
    logic [AW-1:0] r_addr_a, r_addr_b;

    logic [CW-1:0] row_a, row_b, rd_col;
    logic [AW-1:0] raddr_a, raddr_b, waddr;
    logic [EW-1:0] ram_a, ram_b;
    t_entry        ent_a, ent_b, wdata;
    logic          we, fill, in_range, out_free;
    logic [4:0]    new_dist, cnt_next;

    function automatic t_entry reset_entry(logic [AW-1:0] addr);
        t_entry e;
        e.known    = (addr[AW-1:CW] == addr[CW-1:0]);
        e.distance = 5'd0;
        e.next_hop = 4'(addr[AW-1:CW]);
        return e;
    endfunction

    assign row_a   = r_a[CW-1:0];
    assign row_b   = r_b[CW-1:0];
    assign rd_col  = (r_state == S_RDI) ? r_b[CW-1:0] : r_col;
    assign raddr_a = {row_a, rd_col};
    assign raddr_b = {row_b, r_col};

    dvtu_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (wdata),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (ram_a),
        .o_rdata_b (ram_b)
    );

    assign ent_a = r_va ? t_entry'(ram_a) : reset_entry(r_addr_a);
    assign ent_b = r_vb ? t_entry'(ram_b) : reset_entry(r_addr_b);

    // advertise: fill only entries unknown to the receiver
    assign fill     = r_pend && ent_a.known && !ent_b.known;
    assign new_dist = (ent_a.distance == DIST_MAX) ? DIST_MAX : ent_a.distance + 5'd1;
    assign cnt_next = (fill && (r_cnt != COUNT_MAX)) ? r_cnt + 5'd1 : r_cnt;

    assign in_range = ({5'd0, i_in_item.first_node} < NODES_V)
                   && ({5'd0, i_in_item.second_node} < NODES_V);
    assign out_free = !r_out_vld || i_out_ready;

    always_comb begin
        we    = 1'b0;
        waddr = r_addr_b;
        wdata = '{known: 1'b1, distance: new_dist, next_hop: r_a};
        unique case (r_state)
            S_LINK1: begin
                we    = 1'b1;
                waddr = {row_a, r_b[CW-1:0]};
                wdata = '{known: 1'b1, distance: 5'd1, next_hop: r_b};
            end
            S_LINK2: begin
                we    = 1'b1;
                waddr = {row_b, r_a[CW-1:0]};
                wdata = '{known: 1'b1, distance: 5'd1, next_hop: r_a};
            end
            S_ADV: begin
                we = fill;
            end
            S_ADVT: begin
                we = fill;
            end
            default: begin
                we = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_col     = r_col;
        n_pend    = 1'b0;
        n_cnt     = cnt_next;
        n_res     = r_res;
        n_out     = r_out;
        n_out_vld = r_out_vld;

        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_a   = i_in_item.first_node;
                    n_b   = i_in_item.second_node;
                    n_col = '0;
                    n_cnt = 5'd0;
                    n_res = '0;
                    if (!in_range) begin
                        n_state = S_DONE;
                    end else begin
                        case (t_op'(i_in_item.operation))
                            OP_LINK: n_state = S_LINK1;
                            OP_ADV: begin
                                // self-advertise changes nothing
                                n_state = (i_in_item.first_node == i_in_item.second_node)
                                        ? S_DONE : S_ADV;
                            end
                            OP_READ: n_state = S_RDI;
                            default: n_state = S_DONE;
                        endcase
                    end
                end
            end
            S_LINK1: n_state = S_LINK2;
            S_LINK2: n_state = S_DONE;
            S_ADV: begin
                n_pend = 1'b1;
                n_col  = CW'(r_col + 1'b1);
                if (r_col == LAST_COL) begin
                    n_state = S_ADVT;
                end
            end
            S_ADVT: begin
                n_res.updated_count = cnt_next;
                n_state             = S_DONE;
            end
            S_RDI: n_state = S_RDW;
            S_RDW: begin
                if (ent_a.known) begin
                    n_res.known    = 1'b1;
                    n_res.distance = ent_a.distance;
                    n_res.next_hop = ent_a.next_hop;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out     = r_res;
                    n_out_vld = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_col     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_col     <= n_col;
            r_pend    <= n_pend;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_ent_vld[i] <= 1'b0;
            end
        end else if (we) begin
            r_ent_vld[waddr] <= 1'b1;
        end
    end

    // payload; valid flags sampled alongside the RAM read
    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_cnt    <= n_cnt;
        r_res    <= n_res;
        r_out    <= n_out;
        r_va     <= r_ent_vld[raddr_a];
        r_vb     <= r_ent_vld[raddr_b];
        r_addr_a <= raddr_a;
        r_addr_b <= raddr_b;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

/* rtl/dvtu_checker.sv */
// ----------------------------------------------------------------------------
// dvtu_checker
// Port-level checks on the routing table block, bound to the top level.
// ----------------------------------------------------------------------------
`include "distance_vector_table_update_top_assert.svh"

module dvtu_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input dvtu_pkg::t_out o_out_item
);

    import dvtu_pkg::*;

    logic in_acc;
    logic out_stall;
    logic out_count;
    logic out_unknown;
    logic unknown_zero;

    assign in_acc       = i_in_valid && o_in_ready;
    assign out_stall    = o_out_valid && !i_out_ready;
    assign out_count    = o_out_valid && (o_out_item.updated_count != 5'd0);
    assign out_unknown  = o_out_valid && !o_out_item.known;
    assign unknown_zero = (o_out_item.distance == 5'd0) && (o_out_item.next_hop == 4'd0);

    `DVTU_ASSERT_NEXT(a_out_valid_held, out_stall, o_out_valid)
    `DVTU_ASSERT_NEXT(a_out_item_held, out_stall, $stable(o_out_item))
    // one item in flight: busy straight after acceptance
    `DVTU_ASSERT_NEXT(a_busy_after_accept, in_acc, !o_in_ready)
    // an advertise count never comes with a read answer
    `DVTU_ASSERT_NOW(a_count_not_read, out_count, !o_out_item.known)
    `DVTU_ASSERT_NOW(a_unknown_zero, out_unknown, unknown_zero)

endmodule

bind distance_vector_table_update_top dvtu_checker u_dvtu_checker (.*);

/* bench/tb_distance_vector_table_update_top.sv */
// ----------------------------------------------------------------------------
// tb_distance_vector_table_update_top
// Drives add-link, advertise, read and no-op items into the routing table
// block and checks every result against a local copy of the tables. A short
// directed run is followed by random traffic whose node range widens over
// time, with random idling on both channels and one long output stall.
// ----------------------------------------------------------------------------
module tb_distance_vector_table_update_top;
    import dvtu_pkg::*;

    localparam int NODES      = 16;
    localparam int RAND_ITEMS = 1500;
    localparam int CALM_TAIL  = 200;
    localparam int HOLD_AT    = 300;
    localparam int HOLD_LEN   = 250;
    localparam int DRAIN      = 40;
    localparam int LIMIT      = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic in_valid  = 1'b0;
    t_in  in_item   = '0;
    logic out_ready = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    t_out o_out_item;

    // local copy of the routing tables, row = owner, column = destination
    logic       known_tbl [NODES][NODES];
    logic [4:0] dist_tbl  [NODES][NODES];
    logic [3:0] hop_tbl   [NODES][NODES];

    t_in  pending_items [$];
    t_out route_answers [$];

    int errors         = 0;
    int cycle_count    = 0;
    int accepted_count = 0;
    int gap_left       = 0;
    int stall_left     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit send_bursty    = 1'b1;
    bit recv_bursty    = 1'b1;

    distance_vector_table_update_top #(
        .NODES(NODES)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (in_item),
        .o_out_valid(o_out_valid),
        .i_out_ready(out_ready),
        .o_out_item (o_out_item)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // applies one item to the local tables and returns the result it gives
    function automatic t_out route_outcome(t_in item);
        t_out       res;
        int         a;
        int         b;
        logic [5:0] nd;
        res = '0;
        a   = int'(item.first_node);
        b   = int'(item.second_node);
        if (a < NODES && b < NODES) begin
            case (t_op'(item.operation))
                OP_LINK: begin
                    known_tbl[a][b] = 1'b1;
                    dist_tbl[a][b]  = 5'd1;
                    hop_tbl[a][b]   = item.second_node;
                    known_tbl[b][a] = 1'b1;
                    dist_tbl[b][a]  = 5'd1;
                    hop_tbl[b][a]   = item.first_node;
                end
                OP_ADV: begin
                    if (a != b) begin
                        for (int d = 0; d < NODES; d++) begin
                            if (!known_tbl[b][d] && known_tbl[a][d]) begin
                                nd = {1'b0, dist_tbl[a][d]} + 6'd1;
                                known_tbl[b][d] = 1'b1;
                                dist_tbl[b][d]  = (nd > {1'b0, DIST_MAX}) ? DIST_MAX : nd[4:0];
                                hop_tbl[b][d]   = item.first_node;
                                if (res.updated_count < COUNT_MAX)
                                    res.updated_count = res.updated_count + 5'd1;
                            end
                        end
                    end
                end
                OP_READ: begin
                    if (known_tbl[a][b]) begin
                        res.known    = 1'b1;
                        res.distance = dist_tbl[a][b];
                        res.next_hop = hop_tbl[a][b];
                    end
                end
                default: ;
            endcase
        end
        return res;
    endfunction

    function automatic t_in make_item(t_op op, int a, int b);
        t_in item;
        item.operation   = op;
        item.first_node  = a[3:0];
        item.second_node = b[3:0];
        return item;
    endfunction

    task automatic queue_item(t_op op, int a, int b);
        pending_items.insert(pending_items.size(), make_item(op, a, b));
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        logic nv;
        t_in  ni;
        nv = in_valid;
        ni = in_item;
        if (!i_rst_n) begin
            nv = 1'b0;
            gap_left = 0;
        end else begin
            if (cycle_count % 128 == 0)
                send_bursty = ($urandom_range(0, 2) != 0);
            if (in_valid && o_in_ready) begin
                route_answers.insert(route_answers.size(), route_outcome(in_item));
                accepted_count++;
                nv = 1'b0;
            end
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() >= CALM_TAIL && send_bursty &&
                             $urandom_range(0, 7) == 0) begin
                    gap_left = $urandom_range(1, 6) - 1;
                end else if (pending_items.size() != 0) begin
                    ni = pending_items.pop_front();
                    nv = 1'b1;
                end
            end
        end
        in_valid <= nv;
        in_item  <= ni;
    end

    // receiver, including one long hold-off so that the block backs up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (cycle_count % 128 == 64)
                recv_bursty = ($urandom_range(0, 2) != 0);
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else if (!hold_done && accepted_count >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_left = HOLD_LEN - 1;
                out_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ready <= 1'b0;
            end else if (pending_items.size() >= CALM_TAIL && recv_bursty &&
                         $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && out_ready) begin
            if (route_answers.size() == 0) begin
                $error("result item with no expectation waiting");
                errors++;
            end else begin
                want = route_answers.pop_front();
                check_field("known", int'(want.known), int'(o_out_item.known));
                check_field("distance", int'(want.distance), int'(o_out_item.distance));
                check_field("next_hop", int'(want.next_hop), int'(o_out_item.next_hop));
                check_field("updated_count", int'(want.updated_count),
                            int'(o_out_item.updated_count));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int  span;
        int  pick;
        t_op op;

        for (int r = 0; r < NODES; r++) begin
            for (int c = 0; c < NODES; c++) begin
                known_tbl[r][c] = (r == c);
                dist_tbl[r][c]  = 5'd0;
                hop_tbl[r][c]   = r[3:0];
            end
        end

        // directed: reset contents, links, self cases, overwrite, advertising
        queue_item(OP_READ, 0, 0);
        queue_item(OP_READ, 15, 15);
        queue_item(OP_READ, 0, 15);
        queue_item(OP_READ, 15, 0);
        queue_item(OP_LINK, 0, 1);
        queue_item(OP_LINK, 15, 14);
        queue_item(OP_LINK, 5, 5);
        queue_item(OP_READ, 5, 5);
        queue_item(OP_ADV, 1, 2);
        queue_item(OP_READ, 2, 0);
        queue_item(OP_ADV, 2, 2);
        queue_item(OP_LINK, 0, 2);
        queue_item(OP_READ, 2, 0);
        queue_item(OP_ADV, 0, 15);
        queue_item(OP_READ, 15, 2);
        queue_item(OP_ADV, 15, 14);
        queue_item(OP_READ, 14, 1);
        queue_item(OP_NOP, 15, 15);
        queue_item(OP_NOP, 0, 0);
        queue_item(OP_ADV, 2, 1);
        queue_item(OP_ADV, 5, 3);
        queue_item(OP_READ, 3, 5);
        queue_item(OP_READ, 15, 15);

        // random: the node range widens so that tables fill gradually
        for (int i = 0; i < RAND_ITEMS; i++) begin
            span = (i < 400) ? 3 : (i < 900) ? 7 : 15;
            pick = $urandom_range(0, 99);
            if (pick < 50)
                queue_item(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15));
            else if (pick < 78)
                queue_item(OP_ADV, $urandom_range(0, span), $urandom_range(0, span));
            else if (pick < 93)
                queue_item(OP_LINK, $urandom_range(0, span), $urandom_range(0, span));
            else begin
                op = OP_NOP;
                queue_item(op, $urandom_range(0, 15), $urandom_range(0, 15));
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_items.size() != 0 || in_valid || route_answers.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl
rtl/dvtu_pkg.sv
rtl/dvtu_ram.sv
rtl/distance_vector_table_update_top.sv
rtl/dvtu_checker.sv
bench/tb_distance_vector_table_update_top.sv
